FILE: hw/rtl/kev_pkg.sv
package kev_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned KEY_COUNT_DEF   = 4;

  localparam int unsigned NOW_W     = 48;
  localparam int unsigned TIME_W    = 49;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned KEY_W     = 2;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned ALU_W     = 50;
  localparam int unsigned DIV_STEPS = NOW_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] DELAY_RESET    = 32'd350;
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd90;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_FRAME   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAIN_RD,
    S_DRAIN_EV,
    S_KEY_DIFF,
    S_KEY_CMP,
    S_DIV,
    S_KEY_SUB,
    S_KEY_ADD,
    S_DONE
  } state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

FILE: hw/rtl/key_event_queue_autorepeat_top.sv
// Latency: a key event gives its result in the cycle after it is accepted.
// A tick drains the queued events in order, then visits each key: a key that does not
// repeat is passed over, one under an interval behind gets compare, subtract and add,
// others a long division too (one shared 50-bit adder does all the time arithmetic).
// One request is in work at a time; a new one is taken when the result register is free.
// Reset: empty queue, all key flags and repeat times zero, delay 350 and interval 90.
module key_event_queue_autorepeat_top #(
  parameter int unsigned QUEUE_DEPTH = kev_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned KEY_COUNT   = kev_pkg::KEY_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kev_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kev_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [kev_pkg::KEY_W-1:0]           key_index_i,
  input  logic                                is_down_i,
  input  logic                                is_autorepeat_i,
  input  logic [kev_pkg::NOW_W-1:0]           now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kev_pkg::status_e                    status_o,
  output logic [kev_pkg::MASK_W-1:0]          down_mask_o,
  output logic [kev_pkg::MASK_W-1:0]          pressed_mask_o,
  output logic [kev_pkg::MASK_W-1:0]          repeated_mask_o
);
  import kev_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned ENT_W  = KEY_W + 1;
  localparam int unsigned FL_W   = (KEY_COUNT > MASK_W) ? KEY_COUNT : MASK_W;

  state_e state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [CFG_W-1:0] delay_q, iv_q;
  logic [KEY_COUNT-1:0] held_q, held_d, fresh_q, fresh_d, due_q, due_d;
  logic [TIME_W-1:0] nrt_q [KEY_COUNT];
  logic [TIME_W-1:0] nrt_d [KEY_COUNT];
  logic [NOW_W-1:0] now_q, now_d, diff_q, diff_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  logic [MASK_W-1:0] out_down_q, out_down_d, out_pressed_q, out_pressed_d;
  logic [MASK_W-1:0] out_rep_q, out_rep_d;

  logic ram_we, ram_re;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0] ev_key;
  logic ev_down, ev_in_range, key_last, q_full, in_fire;
  logic [KIDX_W-1:0] ev_idx;
  logic [FL_W-1:0] held_ext, fresh_ext, due_ext;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  kev_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  kev_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  assign head_inc    = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc    = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign q_full      = (tail_inc == head_q);
  assign ram_wdata   = {key_index_i, is_down_i};
  assign ev_key      = ram_rdata[ENT_W-1:1];
  assign ev_down     = ram_rdata[0];
  assign ev_idx      = KIDX_W'(ev_key);
  assign ev_in_range = (32'(ev_key) < KEY_COUNT);
  assign key_last    = (kidx_q == KIDX_W'(KEY_COUNT - 1));
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign held_ext    = FL_W'(held_q);
  assign fresh_ext   = FL_W'(fresh_q);
  assign due_ext     = FL_W'(due_q);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    held_d        = held_q;
    fresh_d       = fresh_q;
    due_d         = due_q;
    nrt_d         = nrt_q;
    now_d         = now_q;
    diff_d        = diff_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    kidx_d        = kidx_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_down_d    = out_down_q;
    out_pressed_d = out_pressed_q;
    out_rep_d     = out_rep_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    alu_req.op    = ALU_SUB;
    alu_req.a     = '0;
    alu_req.b     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (kind_i == KIND_TICK) begin
            now_d   = now_ms_i;
            fresh_d = '0;
            due_d   = '0;
            state_d = S_DRAIN_RD;
          end else begin
            out_valid_d   = 1'b1;
            out_down_d    = '0;
            out_pressed_d = '0;
            out_rep_d     = '0;
            if (is_down_i && is_autorepeat_i) begin
              out_status_d = ST_IGNORED;
            end else if (q_full) begin
              out_status_d = ST_DROPPED;
            end else begin
              out_status_d = ST_QUEUED;
              ram_we       = 1'b1;
              tail_d       = tail_inc;
            end
          end
        end
      end
      S_DRAIN_RD: begin
        if (head_q == tail_q) begin
          kidx_d  = '0;
          state_d = S_KEY_DIFF;
        end else begin
          ram_re  = 1'b1;
          head_d  = head_inc;
          state_d = S_DRAIN_EV;
        end
      end
      S_DRAIN_EV: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(now_q);
        alu_req.b  = ALU_W'(delay_q);
        if (ev_in_range) begin
          if (ev_down) begin
            if (!held_q[ev_idx]) begin
              fresh_d[ev_idx] = 1'b1;
            end
            held_d[ev_idx] = 1'b1;
            nrt_d[ev_idx]  = alu_rsp.res[TIME_W-1:0];
          end else begin
            held_d[ev_idx] = 1'b0;
          end
        end
        state_d = S_DRAIN_RD;
      end
      S_KEY_DIFF: begin
        alu_req.a = ALU_W'(now_q);
        alu_req.b = ALU_W'(nrt_q[kidx_q]);
        if (held_q[kidx_q] && !alu_rsp.borrow) begin
          due_d[kidx_q] = 1'b1;
          diff_d        = alu_rsp.res[NOW_W-1:0];
          state_d       = S_KEY_CMP;
        end else if (key_last) begin
          state_d = S_DONE;
        end else begin
          kidx_d = kidx_q + 1'b1;
        end
      end
      S_KEY_CMP: begin
        alu_req.a = ALU_W'(diff_q);
        alu_req.b = ALU_W'(iv_q);
        if (alu_rsp.borrow) begin
          rem_d   = diff_q[CFG_W-1:0];
          state_d = S_KEY_SUB;
        end else begin
          rem_d   = '0;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        alu_req.a = ALU_W'({rem_q, diff_q[NOW_W-1]});
        alu_req.b = ALU_W'(iv_q);
        if (alu_rsp.borrow) begin
          rem_d = {rem_q[CFG_W-2:0], diff_q[NOW_W-1]};
        end else begin
          rem_d = alu_rsp.res[CFG_W-1:0];
        end
        diff_d = {diff_q[NOW_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = S_KEY_SUB;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_KEY_SUB: begin
        alu_req.a = ALU_W'(now_q);
        alu_req.b = ALU_W'(rem_q);
        diff_d    = alu_rsp.res[NOW_W-1:0];
        state_d   = S_KEY_ADD;
      end
      S_KEY_ADD: begin
        alu_req.op    = ALU_ADD;
        alu_req.a     = ALU_W'(diff_q);
        alu_req.b     = ALU_W'(iv_q);
        nrt_d[kidx_q] = alu_rsp.res[TIME_W-1:0];
        if (key_last) begin
          state_d = S_DONE;
        end else begin
          kidx_d  = kidx_q + 1'b1;
          state_d = S_KEY_DIFF;
        end
      end
      S_DONE: begin
        out_valid_d   = 1'b1;
        out_status_d  = ST_FRAME;
        out_down_d    = held_ext[MASK_W-1:0];
        out_pressed_d = fresh_ext[MASK_W-1:0];
        out_rep_d     = due_ext[MASK_W-1:0];
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      fresh_q     <= '0;
      due_q       <= '0;
      out_valid_q <= 1'b0;
      kidx_q      <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
        nrt_q[i] <= '0;
      end
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      held_q      <= held_d;
      fresh_q     <= fresh_d;
      due_q       <= due_d;
      out_valid_q <= out_valid_d;
      kidx_q      <= kidx_d;
      cnt_q       <= cnt_d;
      nrt_q       <= nrt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
      iv_q    <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DELAY: begin
          delay_q <= cfg_wdata_i;
        end
        REG_INTERVAL: begin
          iv_q <= (cfg_wdata_i == '0) ? CFG_W'(1) : cfg_wdata_i;
        end
        default: begin
          delay_q <= delay_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    now_q         <= now_d;
    diff_q        <= diff_d;
    rem_q         <= rem_d;
    out_status_q  <= out_status_d;
    out_down_q    <= out_down_d;
    out_pressed_q <= out_pressed_d;
    out_rep_q     <= out_rep_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign down_mask_o     = out_down_q;
  assign pressed_mask_o  = out_pressed_q;
  assign repeated_mask_o = out_rep_q;

  // A repeat only fires for a held key, and the held flags change only while draining.
  a_due_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & ~held_q) == '0)
    else $error("repeat flag set for a key that is not held");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> !out_valid_q)
    else $error("frame result would overwrite a pending result");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < iv_q)
    else $error("partial remainder not below the interval");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN_RD && head_q == tail_q) |=> state_q == S_KEY_DIFF)
    else $error("drain did not stop at an empty queue");

endmodule

FILE: hw/rtl/kev_ram.sv
module kev_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/kev_alu.sv
module kev_alu (
  input  kev_pkg::alu_req_t req_i,
  output kev_pkg::alu_rsp_t rsp_o
);
  import kev_pkg::*;

  logic             is_sub;
  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   sum;

  assign is_sub = (req_i.op == ALU_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;
  assign sum    = {1'b0, req_i.a} + {1'b0, b_eff} + (ALU_W+1)'(is_sub);

  assign rsp_o.res    = sum[ALU_W-1:0];
  assign rsp_o.borrow = is_sub & ~sum[ALU_W];

endmodule
